// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is asserted
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// concurrent check that also holds through reset
`define ASSERT_CLKD_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/gspub_pkg.sv =====
package gspub_pkg;

    localparam int TIME_BITS     = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [TIME_BITS:0]   time_ext_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE     = 2'd0,
        CMD_INVALIDATE = 2'd1,
        CMD_TICK       = 2'd2,
        CMD_COLLISION  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        TXLOCK_NONE    = 2'd0,
        TXLOCK_NO_ACK  = 2'd1,
        TXLOCK_BUSOFF  = 2'd2,
        TXLOCK_COLLIDE = 2'd3
    } latch_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TX_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RX      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ACK     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BUS_OFF = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BACKOFF_MIN = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BACKOFF_MAX = 3'd6;

    localparam logic [15:0] RST_STALE_LIMIT = 16'd1000;
    localparam logic [15:0] RST_MIN_RX      = 16'd10;
    localparam logic [7:0]  RST_MAX_ACK     = 8'd5;
    localparam logic [7:0]  RST_MAX_BUS_OFF = 8'd3;
    localparam logic [15:0] RST_BACKOFF_MIN = 16'd5000;
    localparam logic [15:0] RST_BACKOFF_MAX = 16'd60000;

    localparam logic [15:0] UNKNOWN16   = 16'hFFFF;
    localparam logic [15:0] HEADING_MAX = 16'd3599;
    localparam logic [7:0]  AGE_SAT     = 8'hFF;

    // age / 10 by reciprocal, exact for ages below the saturation point
    localparam int          AGE_SAT_LIMIT = 2560;
    localparam logic [12:0] DIV10_MUL     = 13'd6554;
    localparam int          DIV10_SHIFT   = 16;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] speed_value;
        logic        fix_flag;
        logic [15:0] heading_value;
        logic        heading_given;
        logic [31:0] now_ms;
        logic [15:0] bus_off_total;
        logic [7:0]  ack_fail_run;
        logic [15:0] rx_frames_seen;
        logic        controller_ready;
        logic        link_connected;
    } in_item_t;

    typedef struct packed {
        logic        frame_sent;
        logic [15:0] speed_word;
        logic [15:0] heading_word;
        logic [3:0]  status_byte;
        logic [7:0]  age_byte;
        logic [7:0]  sequence_byte;
        logic [7:0]  check_byte;
        latch_t      latch_state;
    } out_item_t;

endpackage

// ===== hdl/gps_speed_can_publisher.sv =====
// GPS speed publisher for the vehicle bus.
// Input channel s_valid/s_ready/s_data carries commands: gps sample,
// invalidate, period tick and id collision. Only a period tick yields a
// result on m_valid/m_ready/m_data; the other commands update held state.
// A result carries the 8-byte frame fields when armed, else zeros with the
// latch state. Configuration is written through cfg_we/cfg_index/cfg_wdata,
// one register per cycle; the user must write it only while the block is
// idle, which the block does not enforce. An item lands in the input
// register; a tick's result is registered in the result register and shown
// on m_valid. Throughput: one item per cycle while no tick waits on a
// stalled receiver, set by the single input register to result register pass.
// Reset (aresetn low, synchronous) clears both stages, the held sample,
// latches, frame counter and backoff, and loads the configuration defaults.
// When the receiver stalls, the result register holds; the input register
// keeps taking samples and other commands and stops once a tick waits in it.
module gps_speed_can_publisher (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  gspub_pkg::in_item_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output gspub_pkg::out_item_t                 m_data,
    input  logic                                 cfg_we,
    input  logic [gspub_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [gspub_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import gspub_pkg::*;

    logic        tx_enable_reg;
    logic [15:0] stale_limit_reg;
    logic [15:0] min_rx_reg;
    logic [7:0]  max_ack_reg;
    logic [7:0]  max_bus_off_reg;
    logic [15:0] backoff_max_reg;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic [15:0] held_speed_reg;
    logic [15:0] held_heading_reg;
    logic        held_fix_reg;
    logic        sample_present_reg;
    time_t       sample_time_reg;
    latch_t      latch_reg;
    logic [7:0]  frame_counter_reg;
    logic [15:0] prior_bus_off_reg;
    time_ext_t   backoff_end_reg;
    logic [15:0] backoff_now_reg;

    logic        out_free;
    logic        is_tick;
    logic        fire;
    time_t       now_t;
    logic        bo_changed;
    time_ext_t   backoff_end_next;
    logic [16:0] backoff_doubled;
    logic [15:0] backoff_now_next;
    latch_t      latch_next;
    logic        armed;
    time_t       age;
    logic        stale;
    logic        valid;
    logic [24:0] age_prod;
    logic [7:0]  age10;
    logic [15:0] spd;
    logic [15:0] hdg;
    logic [3:0]  status;
    logic [15:0] sample_heading;
    out_item_t   result;

    assign out_free = !m_valid_reg || m_ready;
    assign is_tick  = (in_item_reg.cmd == CMD_TICK);
    assign fire     = in_valid_reg && (!is_tick || out_free);
    assign s_ready  = !in_valid_reg || fire;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        now_t      = time_t'(in_item_reg.now_ms);
        bo_changed = (in_item_reg.bus_off_total != prior_bus_off_reg);

        backoff_end_next = bo_changed ?
            (time_ext_t'(now_t) + time_ext_t'(backoff_now_reg)) : backoff_end_reg;
        backoff_doubled  = {backoff_now_reg, 1'b0};
        if (backoff_doubled > {1'b0, backoff_max_reg}) begin
            backoff_now_next = backoff_max_reg;
        end else begin
            backoff_now_next = backoff_doubled[15:0];
        end

        latch_next = latch_reg;
        if (latch_reg == TXLOCK_NONE) begin
            if (in_item_reg.ack_fail_run >= max_ack_reg) begin
                latch_next = TXLOCK_NO_ACK;
            end else if (in_item_reg.bus_off_total >= {8'd0, max_bus_off_reg}) begin
                latch_next = TXLOCK_BUSOFF;
            end
        end

        armed = tx_enable_reg && (latch_next == TXLOCK_NONE) &&
                in_item_reg.controller_ready &&
                (in_item_reg.rx_frames_seen >= min_rx_reg) &&
                (time_ext_t'(now_t) >= backoff_end_next);

        if (now_t < sample_time_reg) begin
            age = '0;
        end else begin
            age = now_t - sample_time_reg;
        end
        stale = !sample_present_reg || (age > time_t'(stale_limit_reg));
        valid = held_fix_reg && !stale && (held_speed_reg != UNKNOWN16);

        age_prod = 25'(age[11:0]) * 25'(DIV10_MUL);
        if (!sample_present_reg || (age >= time_t'(AGE_SAT_LIMIT))) begin
            age10 = AGE_SAT;
        end else begin
            age10 = age_prod[DIV10_SHIFT +: 8];
        end

        spd    = valid ? held_speed_reg : UNKNOWN16;
        hdg    = valid ? held_heading_reg : UNKNOWN16;
        status = {stale, in_item_reg.link_connected, held_fix_reg, valid};

        result             = '0;
        result.latch_state = latch_next;
        if (armed) begin
            result.frame_sent    = 1'b1;
            result.speed_word    = spd;
            result.heading_word  = hdg;
            result.status_byte   = status;
            result.age_byte      = age10;
            result.sequence_byte = frame_counter_reg;
            result.check_byte    = spd[7:0] ^ spd[15:8] ^ hdg[7:0] ^ hdg[15:8] ^
                                   {4'd0, status} ^ age10 ^ frame_counter_reg;
        end

        if (!in_item_reg.heading_given ||
            (in_item_reg.heading_value > HEADING_MAX)) begin
            sample_heading = UNKNOWN16;
        end else begin
            sample_heading = in_item_reg.heading_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (out_free && fire && is_tick) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= fire && is_tick;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_enable_reg      <= 1'b0;
            stale_limit_reg    <= RST_STALE_LIMIT;
            min_rx_reg         <= RST_MIN_RX;
            max_ack_reg        <= RST_MAX_ACK;
            max_bus_off_reg    <= RST_MAX_BUS_OFF;
            backoff_max_reg    <= RST_BACKOFF_MAX;
            held_speed_reg     <= UNKNOWN16;
            held_heading_reg   <= UNKNOWN16;
            held_fix_reg       <= 1'b0;
            sample_present_reg <= 1'b0;
            sample_time_reg    <= '0;
            latch_reg          <= TXLOCK_NONE;
            frame_counter_reg  <= '0;
            prior_bus_off_reg  <= '0;
            backoff_end_reg    <= '0;
            backoff_now_reg    <= RST_BACKOFF_MIN;
        end else begin
            if (fire) begin
                case (in_item_reg.cmd)
                    CMD_SAMPLE: begin
                        held_speed_reg     <= in_item_reg.speed_value;
                        held_heading_reg   <= sample_heading;
                        held_fix_reg       <= in_item_reg.fix_flag;
                        sample_time_reg    <= now_t;
                        sample_present_reg <= 1'b1;
                    end
                    CMD_INVALIDATE: begin
                        held_speed_reg     <= UNKNOWN16;
                        held_heading_reg   <= UNKNOWN16;
                        held_fix_reg       <= 1'b0;
                        sample_time_reg    <= '0;
                        sample_present_reg <= 1'b0;
                    end
                    CMD_COLLISION: begin
                        latch_reg <= TXLOCK_COLLIDE;
                    end
                    CMD_TICK: begin
                        if (bo_changed) begin
                            prior_bus_off_reg <= in_item_reg.bus_off_total;
                            backoff_end_reg   <= backoff_end_next;
                            backoff_now_reg   <= backoff_now_next;
                        end
                        latch_reg <= latch_next;
                        if (armed) begin
                            frame_counter_reg <= frame_counter_reg + 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TX_ENABLE:   tx_enable_reg   <= cfg_wdata[0];
                    CFG_STALE_LIMIT: stale_limit_reg <= cfg_wdata;
                    CFG_MIN_RX:      min_rx_reg      <= cfg_wdata;
                    CFG_MAX_ACK:     max_ack_reg     <= cfg_wdata[7:0];
                    CFG_MAX_BUS_OFF: max_bus_off_reg <= cfg_wdata[7:0];
                    CFG_BACKOFF_MIN: backoff_now_reg <= cfg_wdata;
                    CFG_BACKOFF_MAX: backoff_max_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/gspub_checker.sv =====
`include "assert_macros.svh"

module gspub_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input gspub_pkg::out_item_t m_data
);
    import gspub_pkg::*;

    logic       sent;
    logic       unsent;
    logic       frame_blank;
    logic [7:0] frame_xor;

    assign sent        = m_valid && m_data.frame_sent;
    assign unsent      = m_valid && !m_data.frame_sent;
    assign frame_blank = (m_data.speed_word == 16'd0) && (m_data.heading_word == 16'd0) &&
                         (m_data.status_byte == 4'd0) && (m_data.age_byte == 8'd0) &&
                         (m_data.sequence_byte == 8'd0) && (m_data.check_byte == 8'd0);
    assign frame_xor   = m_data.speed_word[7:0] ^ m_data.speed_word[15:8] ^
                         m_data.heading_word[7:0] ^ m_data.heading_word[15:8] ^
                         {4'd0, m_data.status_byte} ^ m_data.age_byte ^
                         m_data.sequence_byte;

    `ASSERT_CLKD(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `ASSERT_CLKD_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)
    `ASSERT_CLKD(a_idle_frame_zero, aclk, aresetn, unsent |-> frame_blank)
    `ASSERT_CLKD(a_check_xor, aclk, aresetn, sent |-> m_data.check_byte == frame_xor)
    `ASSERT_CLKD(a_sent_unlatched, aclk, aresetn, sent |-> m_data.latch_state == TXLOCK_NONE)

endmodule

bind gps_speed_can_publisher gspub_checker u_gspub_checker (.*);
